/* rtl/core/sld_pkg.sv */
// Shared types, constants and codes for the start/length frame deframer.
`default_nettype none

package sld_pkg;

    localparam int unsigned NUM_CHANNELS = 2;

    localparam int unsigned LEN_W   = 15;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h68;
    localparam logic [BYTE_W-1:0] STOP_BYTE  = 8'h16;

    localparam logic [LEN_W-1:0] MIN_TOTAL    = 15'd12;
    localparam logic [LEN_W-1:0] LEN_ADD      = 15'd5;
    localparam int unsigned      LEN_SHIFT    = 2;
    localparam logic [13:0]      MIN_USER     = 14'd6;
    localparam logic [LEN_W-1:0] HEADER_BYTES = 15'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RST  = 15'd512;

    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_STORED   = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ABORTED  = 2'd3
    } frame_status_t;

    // Per-channel framing context, one memory word
    typedef struct packed {
        logic              in_frame;
        logic [LEN_W-1:0]  byte_count;
        logic [LEN_W-1:0]  expected_total;
        logic [BYTE_W-1:0] length_low_byte;
    } chan_state_t;

    // Per-beat report from the frame logic
    typedef struct packed {
        logic [LEN_W-1:0] position;
        frame_status_t    status;
        logic [LEN_W-1:0] total;
    } beat_report_t;

endpackage

`default_nettype wire

/* rtl/core/sld_state_mem.sv */
// Per-channel context memory: registered read, valid bits, last-write bypass.
`default_nettype none

module sld_state_mem #(
    parameter int unsigned NUM_CHANNELS = sld_pkg::NUM_CHANNELS,
    parameter int unsigned ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output sld_pkg::chan_state_t      rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire sld_pkg::chan_state_t wr_data
);

    sld_pkg::chan_state_t ram_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;

    sld_pkg::chan_state_t rdata_reg;
    logic                 rvalid_reg;
    logic [ADDR_W-1:0]    raddr_reg;

    // Last write; always the newest copy of its entry
    sld_pkg::chan_state_t byp_data_reg;
    logic [ADDR_W-1:0]    byp_addr_reg;
    logic                 byp_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= ram_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            raddr_reg     <= '0;
            byp_valid_reg <= 1'b0;
            byp_addr_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                byp_valid_reg      <= 1'b1;
                byp_addr_reg       <= wr_addr;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
                raddr_reg  <= rd_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (byp_valid_reg && (byp_addr_reg == raddr_reg))
        begin
            rd_data = byp_data_reg;
        end
        else if (rvalid_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sld_frame_logic.sv */
// Framing rules: next channel context and beat report from one byte.
`default_nettype none

module sld_frame_logic (
    input  wire sld_pkg::chan_state_t          cur,
    input  wire logic [sld_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic [sld_pkg::LEN_W-1:0]     max_len,
    output sld_pkg::chan_state_t               nxt,
    output sld_pkg::beat_report_t              report
);

    logic [15:0]               len_word;
    logic [13:0]               len_field;
    logic [sld_pkg::LEN_W-1:0] count_inc;

    always_comb
    begin
        len_word  = {data_byte, cur.length_low_byte};
        len_field = len_word[15:sld_pkg::LEN_SHIFT];
        count_inc = cur.byte_count + 15'd1;

        nxt             = cur;
        report.position = '0;
        report.status   = sld_pkg::ST_IGNORED;
        report.total    = '0;

        if (!cur.in_frame)
        begin
            if (data_byte == sld_pkg::START_BYTE)
            begin
                nxt.in_frame       = 1'b1;
                nxt.byte_count     = 15'd1;
                nxt.expected_total = '0;
                report.status      = sld_pkg::ST_STORED;
            end
        end
        else
        begin
            report.position = cur.byte_count;
            priority if (cur.byte_count >= max_len)
            begin
                report.status = sld_pkg::ST_ABORTED;
            end
            else if (cur.byte_count <= 15'd1)
            begin
                nxt.length_low_byte = data_byte;
                nxt.byte_count      = 15'd2;
                report.status       = sld_pkg::ST_STORED;
            end
            else if (cur.byte_count == 15'd2)
            begin
                nxt.expected_total = (len_field < sld_pkg::MIN_USER) ? '0
                                   : {1'b0, len_field} + sld_pkg::LEN_ADD;
                nxt.byte_count     = 15'd3;
                report.status      = sld_pkg::ST_STORED;
            end
            else if (cur.byte_count == 15'd3)
            begin
                if ((data_byte != sld_pkg::START_BYTE)
                    || (cur.expected_total < sld_pkg::MIN_TOTAL)
                    || (cur.expected_total > max_len))
                begin
                    report.status = sld_pkg::ST_ABORTED;
                end
                else
                begin
                    nxt.byte_count = sld_pkg::HEADER_BYTES;
                    report.status  = sld_pkg::ST_STORED;
                end
            end
            else
            begin
                nxt.byte_count = count_inc;
                if ((cur.expected_total != '0) && (count_inc >= cur.expected_total))
                begin
                    if (data_byte == sld_pkg::STOP_BYTE)
                    begin
                        report.status = sld_pkg::ST_COMPLETE;
                        report.total  = cur.expected_total;
                    end
                    else
                    begin
                        report.status = sld_pkg::ST_ABORTED;
                    end
                end
                else
                begin
                    report.status = sld_pkg::ST_STORED;
                end
            end

            // Frame over either way: back to hunting
            if ((report.status == sld_pkg::ST_ABORTED)
                || (report.status == sld_pkg::ST_COMPLETE))
            begin
                nxt = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/start_length_frame_deframer.sv */
// Top level of the start/length frame deframer.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+--------------------------------------
//   input     | in        | in_valid / in_ready  | channel, data_byte
//   result    | out       | out_valid/ out_ready | out_channel, out_byte, byte_position,
//             |           |                      | frame_status, frame_len
//   config    | in        | cfg_wr_en            | cfg_wr_data (max_frame_len)
//
// One beat per cycle while out_ready keeps the output draining; each beat's
// context is read at acceptance into the update stage, and its update goes
// into the output register when that stage moves on.
// The per-channel context read-modify-write sets the rate; a bypass of the
// last write lets same-channel beats follow each other back to back.
// Reset clears all contexts at once through per-entry valid bits; no sweep.
// A stall on out_ready holds the update stage; one more beat can be taken
// while the output register is full, then in_ready drops.
`default_nettype none

module start_length_frame_deframer #(
    parameter int unsigned NUM_CHANNELS = sld_pkg::NUM_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          channel,
    input  wire logic [sld_pkg::BYTE_W-1:0]    data_byte,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_channel,
    output logic [sld_pkg::BYTE_W-1:0]         out_byte,
    output logic [sld_pkg::LEN_W-1:0]          byte_position,
    output logic [1:0]                         frame_status,
    output logic [sld_pkg::LEN_W-1:0]          frame_len,

    input  wire logic                          cfg_wr_en,
    input  wire logic [sld_pkg::LEN_W-1:0]     cfg_wr_data
);

    localparam int unsigned ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Config register
    logic [sld_pkg::LEN_W-1:0] max_len_reg;

    // Update stage (context read is in flight into it)
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_channel_reg;
    logic [sld_pkg::BYTE_W-1:0] s1_byte_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_channel_reg;
    logic [sld_pkg::BYTE_W-1:0]  out_byte_reg;
    sld_pkg::beat_report_t       out_report_reg;

    logic                  in_beat;
    logic                  s1_go;
    logic [ADDR_W-1:0]     in_addr;
    sld_pkg::chan_state_t  ctx_cur;
    sld_pkg::chan_state_t  ctx_nxt;
    sld_pkg::beat_report_t report;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_beat  = in_valid && in_ready;

    // Channels without their own context share channel 0
    assign in_addr = (32'(channel) < NUM_CHANNELS) ? ADDR_W'(channel) : '0;

    sld_state_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_beat),
        .rd_addr (in_addr),
        .rd_data (ctx_cur),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data (ctx_nxt)
    );

    sld_frame_logic u_logic (
        .cur       (ctx_cur),
        .data_byte (s1_byte_reg),
        .max_len   (max_len_reg),
        .nxt       (ctx_nxt),
        .report    (report)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_beat)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= sld_pkg::MAX_LEN_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_channel_reg <= channel;
            s1_byte_reg    <= data_byte;
            s1_addr_reg    <= in_addr;
        end
        if (s1_go)
        begin
            out_channel_reg <= s1_channel_reg;
            out_byte_reg    <= s1_byte_reg;
            out_report_reg  <= report;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign out_byte      = out_byte_reg;
    assign byte_position = out_report_reg.position;
    assign frame_status  = out_report_reg.status;
    assign frame_len     = out_report_reg.total;

endmodule

`default_nettype wire

/* rtl/core/sld_checker.sv */
// Port-level checks for the deframer, bound to the top level.
`default_nettype none

module sld_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          out_channel,
    input wire logic [sld_pkg::BYTE_W-1:0]    out_byte,
    input wire logic [sld_pkg::LEN_W-1:0]     byte_position,
    input wire logic [1:0]                    frame_status,
    input wire logic [sld_pkg::LEN_W-1:0]     frame_len
);

    // Held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_channel) && $stable(frame_status)
            && $stable(byte_position) && $stable(frame_len))
        else $error("result beat changed while stalled");

    // Length only reported on completion
    a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != sld_pkg::ST_COMPLETE) |-> frame_len == '0)
        else $error("frame_len set without completion");

    // Completion: stop byte, sane length, last position
    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == sld_pkg::ST_COMPLETE) |->
            (out_byte == sld_pkg::STOP_BYTE) && (frame_len >= sld_pkg::MIN_TOTAL)
            && (byte_position + 15'd1 == frame_len))
        else $error("bad completion beat");

    // Hunting beats sit at position zero; a frame opens on the start byte
    a_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == sld_pkg::ST_STORED) && (byte_position == '0)
            |-> out_byte == sld_pkg::START_BYTE)
        else $error("frame opened on wrong byte");

    a_ignored_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == sld_pkg::ST_IGNORED) |-> byte_position == '0)
        else $error("ignored beat with nonzero position");

endmodule

bind start_length_frame_deframer sld_checker u_sld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_byte      (out_byte),
    .byte_position (byte_position),
    .frame_status  (frame_status),
    .frame_len     (frame_len)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the start/length frame deframer.
`timescale 1ns / 1ps

module testbench;

    // The cycle limit leaves room for a correct run: every beat at the slowest
    // pacing, drain gaps between sections and one long hold-off.
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned LANE_BYTES  = 100;
    localparam int unsigned LIMIT_TOP   = 16388;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned TOTAL_MIN   = 32'(sld_pkg::MIN_TOTAL);
    localparam int unsigned HDR_LEN     = 32'(sld_pkg::HEADER_BYTES);

    typedef logic [sld_pkg::BYTE_W-1:0] byte_t;
    typedef logic [sld_pkg::LEN_W-1:0]  len_t;

    // Ways a generated frame can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_START,    // start byte replaced, frame is only noise
        FLAW_SECOND,   // second start byte wrong
        FLAW_SHORT,    // user length of 6 or less, total below the minimum
        FLAW_LONG,     // total above the configured maximum
        FLAW_STOP,     // last byte is not the stop byte
        FLAW_TRUNC     // frame cut off, next frame runs into it
    } flaw_t;

    typedef struct packed {
        logic  ch;
        byte_t b;
    } rx_beat_t;

    typedef struct packed {
        logic                   ch;
        byte_t                  b;
        len_t                   pos;
        sld_pkg::frame_status_t st;
        len_t                   flen;
    } byte_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic  in_valid = 1'b0;
    logic  in_ready;
    logic  channel = 1'b0;
    byte_t data_byte = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       out_channel;
    byte_t      out_byte;
    len_t       byte_position;
    logic [1:0] frame_status;
    len_t       frame_len;

    logic cfg_wr_en = 1'b0;
    len_t cfg_wr_data = '0;

    // Beats waiting to be offered, and reports predicted for accepted beats
    rx_beat_t     rx_bytes[$];
    byte_report_t pending_reports[$];

    // Per-channel byte streams, merged into rx_bytes at the end of a fill
    byte_t lane0_bytes[$];
    byte_t lane1_bytes[$];

    // Pacing, in percent of cycles
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;

    // Long receiver hold-off, fired once
    logic        hold_req = 1'b0;
    logic        hold_used = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Predictor copy of the register and per-channel framing context
    len_t  frame_limit = sld_pkg::MAX_LEN_RST;
    logic  chan_open    [sld_pkg::NUM_CHANNELS];
    len_t  chan_count   [sld_pkg::NUM_CHANNELS];
    len_t  chan_total   [sld_pkg::NUM_CHANNELS];
    byte_t chan_len_low [sld_pkg::NUM_CHANNELS];

    start_length_frame_deframer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel       (channel),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_channel   (out_channel),
        .out_byte      (out_byte),
        .byte_position (byte_position),
        .frame_status  (frame_status),
        .frame_len     (frame_len),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 clk = ~clk;

    function automatic void clear_chan(int unsigned c);
        chan_open[c]    = 1'b0;
        chan_count[c]   = '0;
        chan_total[c]   = '0;
        chan_len_low[c] = '0;
    endfunction

    // Advance one channel's framing context by one byte and return its report
    function automatic byte_report_t frame_byte_report(logic ch, byte_t b);
        byte_report_t r;
        int unsigned  c;
        len_t         n;
        len_t         t;
        len_t         nxt;
        logic [15:0]  word;
        logic [13:0]  user;
        r.ch   = ch;
        r.b    = b;
        r.pos  = '0;
        r.st   = sld_pkg::ST_IGNORED;
        r.flen = '0;
        // a channel with no context of its own falls back to channel 0
        c = (32'(ch) < sld_pkg::NUM_CHANNELS) ? 32'(ch) : 0;
        if (!chan_open[c])
        begin
            if (b == sld_pkg::START_BYTE)
            begin
                chan_open[c]  = 1'b1;
                chan_count[c] = 15'd1;
                chan_total[c] = '0;
                r.st          = sld_pkg::ST_STORED;
            end
        end
        else
        begin
            n     = chan_count[c];
            t     = chan_total[c];
            r.pos = n;
            if (n >= frame_limit)
            begin
                // limit lowered under a frame in progress
                r.st = sld_pkg::ST_ABORTED;
            end
            else if (n <= 15'd1)
            begin
                chan_len_low[c] = b;
                chan_count[c]   = 15'd2;
                r.st            = sld_pkg::ST_STORED;
            end
            else if (n == 15'd2)
            begin
                word          = {b, chan_len_low[c]};
                user          = word[15:sld_pkg::LEN_SHIFT];
                chan_total[c] = (user < sld_pkg::MIN_USER) ? '0 : user + sld_pkg::LEN_ADD;
                chan_count[c] = 15'd3;
                r.st          = sld_pkg::ST_STORED;
            end
            else if (n == 15'd3)
            begin
                if (b != sld_pkg::START_BYTE || t < sld_pkg::MIN_TOTAL || t > frame_limit)
                begin
                    r.st = sld_pkg::ST_ABORTED;
                end
                else
                begin
                    chan_count[c] = sld_pkg::HEADER_BYTES;
                    r.st          = sld_pkg::ST_STORED;
                end
            end
            else
            begin
                nxt           = n + 15'd1;
                chan_count[c] = nxt;
                if (t != '0 && nxt >= t)
                begin
                    if (b == sld_pkg::STOP_BYTE)
                    begin
                        r.st   = sld_pkg::ST_COMPLETE;
                        r.flen = t;
                        clear_chan(c);
                    end
                    else
                    begin
                        r.st = sld_pkg::ST_ABORTED;
                    end
                end
                else
                begin
                    r.st = sld_pkg::ST_STORED;
                end
            end
            if (r.st == sld_pkg::ST_ABORTED)
                clear_chan(c);
        end
        return r;
    endfunction

    // Sender: offers queued beats, predicts the report of every accepted one.
    // Valid stays up with a steady payload until the beat is taken.
    always @(posedge clk or negedge rst_n)
    begin : drive
        rx_beat_t nb;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int unsigned i = 0; i < sld_pkg::NUM_CHANNELS; i++)
                clear_chan(i);
        end
        else
        begin
            if (in_valid && in_ready)
                pending_reports.push_back(frame_byte_report(channel, data_byte));
            if (!in_valid || in_ready)
            begin
                if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nb = rx_bytes.pop_front();
                    in_valid  <= 1'b1;
                    channel   <= nb.ch;
                    data_byte <= nb.b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compares every accepted report with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        byte_report_t exp_r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected report: ch=%0d byte=%02h pos=%0d st=%0d len=%0d",
                                 out_channel, out_byte, byte_position, frame_status,
                                 frame_len);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_reports.pop_front();
                    if (out_channel !== exp_r.ch || out_byte !== exp_r.b ||
                        byte_position !== exp_r.pos || frame_status !== exp_r.st ||
                        frame_len !== exp_r.flen)
                    begin
                        if (mismatch_count < REPORT_MAX)
                            $display({"report mismatch: exp ch=%0d byte=%02h pos=%0d st=%0d ",
                                      "len=%0d, got ch=%0d byte=%02h pos=%0d st=%0d len=%0d"},
                                     exp_r.ch, exp_r.b, exp_r.pos, exp_r.st, exp_r.flen,
                                     out_channel, out_byte, byte_position, frame_status,
                                     frame_len);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
        end
    end

    // One long receiver hold-off, so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_req && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic put(input logic ch, input byte_t b);
        if (ch)
            lane1_bytes.push_back(b);
        else
            lane0_bytes.push_back(b);
    endtask

    function automatic int unsigned lane_size(logic ch);
        return ch ? lane1_bytes.size() : lane0_bytes.size();
    endfunction

    function automatic byte_t other_than(byte_t v);
        byte_t b;
        do
            b = byte_t'($urandom_range(255));
        while (b == v);
        return b;
    endfunction

    // Total length: mostly short frames, now and then a longer one
    function automatic int unsigned pick_total(int unsigned lim);
        int unsigned cap;
        int unsigned top;
        cap = (lim < TOTAL_MIN) ? TOTAL_MIN : lim;
        top = ($urandom_range(9) == 0) ? 400 : 40;
        if (top > cap)
            top = cap;
        return $urandom_range(top, TOTAL_MIN);
    endfunction

    // Append one frame of the given total length, spoiled as the flaw says, to a channel's lane
    task automatic emit_frame(input logic ch, input int unsigned total, input flaw_t flaw);
        logic [13:0]       user;
        logic [1:0]        pad;
        logic [15:0]       word;
        int unsigned       cut;
        user = 14'(total - 32'(sld_pkg::LEN_ADD));
        if (flaw == FLAW_SHORT)
            user = 14'($urandom_range(32'(sld_pkg::MIN_USER)));    // 6 gives a total of 11
        pad  = 2'($urandom_range(3));
        word = {user, pad};
        put(ch, (flaw == FLAW_START) ? other_than(sld_pkg::START_BYTE) : sld_pkg::START_BYTE);
        put(ch, word[7:0]);
        put(ch, word[15:8]);
        put(ch, (flaw == FLAW_SECOND) ? other_than(sld_pkg::START_BYTE) : sld_pkg::START_BYTE);
        // header-level faults: the rest of the frame would only be noise
        if (flaw == FLAW_START || flaw == FLAW_SECOND || flaw == FLAW_SHORT ||
            flaw == FLAW_LONG)
            return;
        cut = (flaw == FLAW_TRUNC) ? $urandom_range(total - 1, HDR_LEN) : total - 1;
        for (int unsigned p = HDR_LEN; p < cut; p++)
            put(ch, byte_t'($urandom_range(255)));
        if (flaw == FLAW_TRUNC)
            return;
        put(ch, (flaw == FLAW_STOP) ? other_than(sld_pkg::STOP_BYTE) : sld_pkg::STOP_BYTE);
    endtask

    // Interleave both lanes into the sender queue, byte by byte at random
    task automatic merge_lanes();
        rx_beat_t nb;
        @(negedge clk);
        while (lane0_bytes.size() != 0 || lane1_bytes.size() != 0)
        begin
            if (lane1_bytes.size() == 0 ||
                (lane0_bytes.size() != 0 && $urandom_range(1) == 0))
            begin
                nb.ch = 1'b0;
                nb.b  = lane0_bytes.pop_front();
            end
            else
            begin
                nb.ch = 1'b1;
                nb.b  = lane1_bytes.pop_front();
            end
            rx_bytes.push_back(nb);
        end
    endtask

    task automatic drain();
        while (rx_bytes.size() != 0 || in_valid || pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called with nothing in flight
    task automatic set_limit(input len_t v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        frame_limit <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_pace(input int unsigned s_idle, input int unsigned r_stall);
        @(posedge clk);
        send_idle  <= s_idle;
        recv_stall <= r_stall;
    endtask

    // One random phase: mostly well-formed frames with random bodies, the
    // rest spoiled frames and stray noise bytes between frames
    task automatic run_phase(input int unsigned s_idle, input int unsigned r_stall,
                             input int unsigned lim, input bit with_hold);
        int unsigned r;
        int unsigned total;
        int unsigned top;
        flaw_t       flaw;
        set_limit(len_t'(lim));
        set_pace(s_idle, r_stall);
        for (int ln = 0; ln < 2; ln++)
        begin
            while (lane_size(1'(ln)) < LANE_BYTES)
            begin
                if ($urandom_range(99) < 15)
                    put(1'(ln), byte_t'($urandom_range(255)));
                r     = $urandom_range(99);
                flaw  = (r < 70) ? FLAW_NONE : flaw_t'(1 + r % 6);
                total = pick_total(lim);
                if (flaw == FLAW_LONG)
                begin
                    if (lim >= LIMIT_TOP)
                    begin
                        flaw = FLAW_NONE;
                    end
                    else
                    begin
                        top   = (lim + 100 > LIMIT_TOP) ? LIMIT_TOP : lim + 100;
                        total = $urandom_range(top, lim + 1);
                    end
                end
                emit_frame(1'(ln), total, flaw);
            end
        end
        merge_lanes();
        if (with_hold)
        begin
            @(posedge clk);
            hold_req <= 1'b1;
        end
        drain();
    endtask

    task automatic push_beat(input logic ch, input byte_t b);
        rx_beat_t nb;
        nb.ch = ch;
        nb.b  = b;
        rx_bytes.push_back(nb);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, under the reset maximum of 512.
        // ch0: shortest legal frame (user length 7, total 12), held open at
        // position 10. ch1 interleaved: user length 6, total 11, aborts at
        // the second start byte.
        @(negedge clk);
        push_beat(1'b0, sld_pkg::START_BYTE);
        push_beat(1'b1, sld_pkg::START_BYTE);
        push_beat(1'b0, 8'h1F);
        push_beat(1'b1, 8'h18);
        push_beat(1'b0, 8'h00);
        push_beat(1'b1, 8'h00);
        push_beat(1'b0, sld_pkg::START_BYTE);
        push_beat(1'b1, sld_pkg::START_BYTE);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, sld_pkg::STOP_BYTE);
        push_beat(1'b0, sld_pkg::START_BYTE);
        push_beat(1'b0, 8'hA5);
        push_beat(1'b0, 8'h5A);
        push_beat(1'b0, 8'h7E);
        drain();

        // Maximum below 12: the open ch0 frame is now over the limit, so its
        // stop byte aborts; a new total-12 header on ch1 aborts as too long.
        set_limit(15'd11);
        @(negedge clk);
        push_beat(1'b0, sld_pkg::STOP_BYTE);
        push_beat(1'b1, sld_pkg::START_BYTE);
        push_beat(1'b1, 8'h1C);
        push_beat(1'b1, 8'h00);
        push_beat(1'b1, sld_pkg::START_BYTE);
        drain();

        // Length word 0xFFFF, total 16388: too long one below the top maximum
        set_limit(len_t'(LIMIT_TOP - 1));
        @(negedge clk);
        push_beat(1'b0, sld_pkg::START_BYTE);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, sld_pkg::START_BYTE);
        drain();

        // Same header accepted at the top maximum, a few body bytes follow
        set_limit(len_t'(LIMIT_TOP));
        @(negedge clk);
        push_beat(1'b1, sld_pkg::START_BYTE);
        push_beat(1'b1, 8'hFF);
        push_beat(1'b1, 8'hFF);
        push_beat(1'b1, sld_pkg::START_BYTE);
        push_beat(1'b1, byte_t'($urandom_range(255)));
        push_beat(1'b1, byte_t'($urandom_range(255)));
        push_beat(1'b1, byte_t'($urandom_range(255)));
        drain();

        // Maximum dropped under the open ch1 frame: its next byte aborts
        set_limit(15'd6);
        @(negedge clk);
        push_beat(1'b1, sld_pkg::STOP_BYTE);
        drain();

        // Random phases across pacing and maximum settings
        run_phase(0, 0, 300, 1'b1);
        run_phase(55, 0, TOTAL_MIN, 1'b0);
        run_phase(0, 55, $urandom_range(600, 13), 1'b0);
        run_phase(35, 35, LIMIT_TOP, 1'b0);

        // Anything late or extra shows up within this tail
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
